// ===== rtl/sm3_compress_four_lane_defines.svh =====
// Assertion macros for the four-lane SM3 compression block.
// Used by the top level; no other dependencies.
`ifndef SM3_COMPRESS_FOUR_LANE_DEFINES_SVH
`define SM3_COMPRESS_FOUR_LANE_DEFINES_SVH
// Assert an implication, disabled during reset.
`define SM3_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sm3 assertion failed");
// Assert a condition that always holds outside reset.
`define SM3_ASSERT_ALW(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sm3 assertion failed");
`endif

// ===== rtl/sm3_pkg.sv =====
// Shared types, constants and functions for the SM3 compression block.
// No dependencies.
package sm3_pkg;
  localparam int LANES_DEF = 4;
  localparam int IN_LANES = 4;
  localparam logic [31:0] TJ_LO = 32'h79cc4519;
  localparam logic [31:0] TJ_HI = 32'h7a879d8a;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

  function automatic logic [31:0] iv(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h7380166f;
      3'd1: r = 32'h4914b2b9;
      3'd2: r = 32'h172442d7;
      3'd3: r = 32'hda8a0600;
      3'd4: r = 32'ha96f30bc;
      3'd5: r = 32'h163138aa;
      3'd6: r = 32'he38dee4d;
      default: r = 32'hb0fb0e4e;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        we;
    logic [6:0]  waddr;
    logic [6:0]  raddr;
  } wmem_ctl_t;
endpackage

// ===== rtl/sm3_if.sv =====
// Valid/ready channel interfaces for the SM3 block.
// Depends on nothing.
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_lane0;
  logic [31:0] word_lane1;
  logic [31:0] word_lane2;
  logic [31:0] word_lane3;
  logic        start_new;
  modport source(output valid, word_lane0, word_lane1, word_lane2, word_lane3,
                 start_new, input ready);
  modport sink(input valid, word_lane0, word_lane1, word_lane2, word_lane3,
               start_new, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_lane0;
  logic [31:0] digest_lane1;
  logic [31:0] digest_lane2;
  logic [31:0] digest_lane3;
  logic [2:0]  digest_index;
  logic        last;
  modport source(output valid, digest_lane0, digest_lane1, digest_lane2, digest_lane3,
                 digest_index, last, input ready);
  modport sink(input valid, digest_lane0, digest_lane1, digest_lane2, digest_lane3,
               digest_index, last, output ready);
endinterface

// ===== rtl/sm3_compress_four_lane.sv =====
// SM3 compression, four lanes. The sixteen words of a block are taken while collecting;
// the sixteenth starts a block run of 52 expansion steps (five reads from the schedule
// memory, then the write), a setup state, 64 rounds and a fold state, after which the
// 8 results are presented, each held until the sink takes it. No new word is taken
// until the last result has gone.
// Reset (synchronous, rst high) loads the IV and clears the word count.
module sm3_compress_four_lane #(
  parameter int LANES = sm3_pkg::LANES_DEF
) (
  input logic clk,
  input logic rst,
  sm3_in_if.sink   in_ch,
  sm3_out_if.source out_ch
);
  `include "sm3_compress_four_lane_defines.svh"

  localparam int LW = LANES * 32;

  typedef enum logic [5:0] {
    S_COLLECT = 6'b000001,
    S_EXP     = 6'b000010,
    S_RINIT   = 6'b000100,
    S_ROUND   = 6'b001000,
    S_FINAL   = 6'b010000,
    S_OUT     = 6'b100000
  } state_t;

  state_t state;
  logic [3:0] word_count;
  logic [6:0] j;         // expansion index or round index
  logic [1:0] ph;        // sub-step within an expansion step
  logic [2:0] oidx;

  logic [31:0] cv  [8][LANES];
  logic [31:0] wr  [8][LANES];
  logic [31:0] t_a [LANES];   // expansion scratch
  logic [31:0] w_j [LANES];

  sm3_pkg::wmem_ctl_t ctl;
  logic [6:0]  raddr2;
  logic [LW-1:0] wdata, rdata, rdata2;

  sm3_wmem #(.LANES(LANES)) u_wmem (
    .clk(clk), .ctl(ctl), .wdata(wdata), .raddr2(raddr2),
    .rdata(rdata), .rdata2(rdata2)
  );

  logic accept;
  assign in_ch.ready = (state == S_COLLECT);
  assign accept = in_ch.valid && in_ch.ready;

  // Gather words of the input, zero past the fourth lane.
  logic [LW-1:0] in_words;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      unique case (l)
        0: in_words[l*32 +: 32] = in_ch.word_lane0;
        1: in_words[l*32 +: 32] = in_ch.word_lane1;
        2: in_words[l*32 +: 32] = in_ch.word_lane2;
        3: in_words[l*32 +: 32] = in_ch.word_lane3;
        default: in_words[l*32 +: 32] = '0;
      endcase
    end
  end

  logic [3:0] wslot;
  assign wslot = in_ch.start_new ? 4'd0 : word_count;

  // Expansion: ph0 read j-16 and j-9; ph1 read j-3 and j-13; ph2 read j-6; ph3 write.
  logic [LW-1:0] exp_res;
  logic [31:0] tc_rot;
  logic [LW-1:0] round_w;
  always_comb begin
    ctl = '0;
    raddr2 = '0;
    wdata = in_words;
    exp_res = '0;
    unique case (state)
      S_COLLECT: begin
        ctl.we = accept;
        ctl.waddr = {3'd0, wslot};
      end
      S_EXP: begin
        unique case (ph)
          2'd0: begin ctl.raddr = j - 7'd16; raddr2 = j - 7'd9; end
          2'd1: begin ctl.raddr = j - 7'd3; raddr2 = j - 7'd13; end
          2'd2: begin ctl.raddr = j - 7'd6; raddr2 = j - 7'd6; end
          default: begin
            ctl.we = 1'b1;
            ctl.waddr = j;
          end
        endcase
      end
      S_RINIT: begin ctl.raddr = 7'd0; raddr2 = 7'd4; end
      S_ROUND: begin ctl.raddr = j + 7'd1; raddr2 = j + 7'd5; end
      default: ;
    endcase
    for (int l = 0; l < LANES; l++) begin
      exp_res[l*32 +: 32] = t_a[l] ^ rdata[l*32 +: 32];
    end
    if (state == S_EXP) wdata = exp_res;
  end

  assign tc_rot = sm3_pkg::rotl((j < 7'd16) ? sm3_pkg::TJ_LO : sm3_pkg::TJ_HI, j[4:0]);
  assign round_w = rdata;

  logic [31:0] rn [8][LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [31:0] a12, ss1, ss2, ff, gg, w, wp;
      a12 = sm3_pkg::rotl(wr[0][l], 5'd12);
      ss1 = sm3_pkg::rotl(a12 + wr[4][l] + tc_rot, 5'd7);
      ss2 = ss1 ^ a12;
      w  = round_w[l*32 +: 32];
      wp = w ^ rdata2[l*32 +: 32];
      if (j < 7'd16) begin
        ff = wr[0][l] ^ wr[1][l] ^ wr[2][l];
        gg = wr[4][l] ^ wr[5][l] ^ wr[6][l];
      end else begin
        ff = (wr[0][l] & wr[1][l]) | (wr[0][l] & wr[2][l]) | (wr[1][l] & wr[2][l]);
        gg = (wr[4][l] & wr[5][l]) | (~wr[4][l] & wr[6][l]);
      end
      rn[0][l] = ff + wr[3][l] + ss2 + wp;
      rn[1][l] = wr[0][l];
      rn[2][l] = sm3_pkg::rotl(wr[1][l], 5'd9);
      rn[3][l] = wr[2][l];
      rn[4][l] = sm3_pkg::p0(gg + wr[7][l] + ss1 + w);
      rn[5][l] = wr[4][l];
      rn[6][l] = sm3_pkg::rotl(wr[5][l], 5'd19);
      rn[7][l] = wr[6][l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      word_count <= '0;
      j <= '0;
      ph <= '0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) begin
        for (int l = 0; l < LANES; l++) begin
          cv[i][l] <= sm3_pkg::iv(3'(i));
          wr[i][l] <= '0;
        end
      end
    end else begin
      unique case (state)
        S_COLLECT: begin
          if (accept) begin
            // Reload IV on a start flag; drop any partial block.
            if (in_ch.start_new) begin
              for (int i = 0; i < 8; i++) begin
                for (int l = 0; l < LANES; l++) cv[i][l] <= sm3_pkg::iv(3'(i));
              end
            end
            word_count <= wslot + 4'd1;
            if (wslot == 4'd15) begin
              state <= S_EXP;
              j <= 7'd16;
              ph <= '0;
            end
          end
        end
        S_EXP: begin
          ph <= ph + 2'd1;
          for (int l = 0; l < LANES; l++) begin
            unique case (ph)
              2'd1: t_a[l] <= rdata[l*32 +: 32] ^ rdata2[l*32 +: 32];
              2'd2: begin
                t_a[l] <= sm3_pkg::p1(t_a[l] ^ sm3_pkg::rotl(rdata[l*32 +: 32], 5'd15))
                          ^ sm3_pkg::rotl(rdata2[l*32 +: 32], 5'd7);
              end
              default: ;
            endcase
          end
          if (ph == 2'd3) begin
            if (j == 7'd67) begin
              state <= S_RINIT;
            end
            j <= j + 7'd1;
          end
        end
        S_RINIT: begin
          // Schedule reads for round 0 are issued here.
          for (int i = 0; i < 8; i++) begin
            for (int l = 0; l < LANES; l++) wr[i][l] <= cv[i][l];
          end
          j <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 8; i++) begin
            for (int l = 0; l < LANES; l++) wr[i][l] <= rn[i][l];
          end
          j <= j + 7'd1;
          if (j == 7'd63) state <= S_FINAL;
        end
        S_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            for (int l = 0; l < LANES; l++) cv[i][l] <= cv[i][l] ^ wr[i][l];
          end
          oidx <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) state <= S_COLLECT;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  // The expansion step above issues the j-6 read at ph2 and folds its data
  // in with t_a at ph3 through exp_res.
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.digest_index = oidx;
  assign out_ch.last = (oidx == 3'd7);
  assign out_ch.digest_lane0 = cv[oidx][0];
  assign out_ch.digest_lane1 = (LANES > 1) ? cv[oidx][(LANES > 1) ? 1 : 0] : '0;
  assign out_ch.digest_lane2 = (LANES > 2) ? cv[oidx][(LANES > 2) ? 2 : 0] : '0;
  assign out_ch.digest_lane3 = (LANES > 3) ? cv[oidx][(LANES > 3) ? 3 : 0] : '0;

  `SM3_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_COLLECT, !in_ch.ready)
  `SM3_ASSERT_IMP(a_last_idx, clk, rst, out_ch.valid && out_ch.last, oidx == 3'd7)
  `SM3_ASSERT_IMP(a_round_range, clk, rst, state == S_ROUND, j < 7'd64)
endmodule

// ===== rtl/sm3_wmem.sv =====
// Message schedule memory: 68 words per lane, one write and two reads.
// Depends on sm3_pkg.
module sm3_wmem #(
  parameter int LANES = sm3_pkg::LANES_DEF
) (
  input  logic                    clk,
  input  sm3_pkg::wmem_ctl_t      ctl,
  input  logic [LANES*32-1:0]     wdata,
  input  logic [6:0]              raddr2,
  output logic [LANES*32-1:0]     rdata,
  output logic [LANES*32-1:0]     rdata2
);
  logic [LANES*32-1:0] mem [68];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    rdata  <= mem[ctl.raddr];
    rdata2 <= mem[raddr2];
  end
endmodule

// ===== tb/sv/sm3_compress_four_lane_checker.sv =====
// Scoreboard for the four-lane SM3 compression block: predicts digest words.
// Depends on sm3_pkg functions and the sm3_in_if / sm3_out_if channel interfaces.
module sm3_compress_four_lane_checker (
  input  logic       clk,
  input  logic       rst,
  sm3_in_if.sink     in_mon,
  sm3_out_if.sink    out_mon,
  output int         fail_count,
  output int         pending_words
);
  typedef struct packed {
    logic [31:0] d0;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] d3;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0] chain [8][4];
  logic [31:0] msg_block [16][4];
  int unsigned block_fill;
  digest_word_t digest_q[$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    int k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [31:0] mix0(input logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] mix1(input logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  task automatic compress_lane(input int ln);
    logic [31:0] w [68];
    logic [31:0] r [8];
    logic [31:0] tc, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = msg_block[j][ln];
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    for (int j = 0; j < 8; j++) r[j] = chain[j][ln];
    for (int j = 0; j < 64; j++) begin
      tc = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(tc, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
      r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4]; r[4] = mix0(tt2);
    end
    for (int j = 0; j < 8; j++) chain[j][ln] ^= r[j];
  endtask

  task automatic absorb_word(input logic [31:0] w0, w1, w2, w3, input logic restart);
    digest_word_t dw;
    if (restart) begin
      for (int i = 0; i < 8; i++)
        for (int l = 0; l < 4; l++) chain[i][l] = sm3_pkg::iv(i[2:0]);
      block_fill = 0;
    end
    msg_block[block_fill][0] = w0;
    msg_block[block_fill][1] = w1;
    msg_block[block_fill][2] = w2;
    msg_block[block_fill][3] = w3;
    block_fill = (block_fill + 1) % 16;
    if (block_fill != 0) return;
    for (int l = 0; l < 4; l++) compress_lane(l);
    for (int k = 0; k < 8; k++) begin
      dw.d0 = chain[k][0]; dw.d1 = chain[k][1];
      dw.d2 = chain[k][2]; dw.d3 = chain[k][3];
      dw.idx = k[2:0];
      dw.last = (k == 7);
      digest_q.push_back(dw);
    end
  endtask

  always @(posedge clk) begin
    digest_word_t got, want;
    if (rst) begin
      for (int i = 0; i < 8; i++)
        for (int l = 0; l < 4; l++) chain[i][l] = sm3_pkg::iv(i[2:0]);
      block_fill = 0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.digest_lane0, out_mon.digest_lane1, out_mon.digest_lane2,
               out_mon.digest_lane3, out_mon.digest_index, out_mon.last};
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected digest word %h", got);
        end else begin
          want = digest_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("digest mismatch: expected %h got %h", want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_word(in_mon.word_lane0, in_mon.word_lane1, in_mon.word_lane2,
                    in_mon.word_lane3, in_mon.start_new);
    end
    pending_words <= digest_q.size();
  end
endmodule

// ===== tb/sv/sm3_compress_four_lane_test.sv =====
// Top of the SM3 four-lane testbench: clock, reset, word stimulus and verdict.
// Depends on sm3_pkg, the channel interfaces, the block and its checker.
module sm3_compress_four_lane_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_words;
  int   cycle_count = 0;
  int   words_sent = 0;
  bit   calm = 1'b0;   // suppress random idling on both sides

  sm3_in_if  in_ch();
  sm3_out_if out_ch();

  sm3_compress_four_lane u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sm3_compress_four_lane_checker u_chk (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always #5 clk = ~clk;

  // Time guard: give up with NOT OK long after even a slow run would finish.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("sm3_compress_four_lane_test NOT OK");
      $finish;
    end
  end

  // Sink side: drop ready at random, about ten percent of the time, except in calm stretches.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 10);
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.word_lane0 <= '0;
    in_ch.word_lane1 <= '0;
    in_ch.word_lane2 <= '0;
    in_ch.word_lane3 <= '0;
    in_ch.start_new <= 1'b0;
  end

  // Present one word and hold it until accepted; idle beforehand at random.
  task automatic send_word(input logic [31:0] w0, w1, w2, w3, input logic restart);
    while (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word_lane0 <= w0;
    in_ch.word_lane1 <= w1;
    in_ch.word_lane2 <= w2;
    in_ch.word_lane3 <= w3;
    in_ch.start_new <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [31:0] rand_word(input int style);
    case (style)
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // Send len words of a block: a start flag on word zero when asked, content by style (zeros, all-ones or random).
  task automatic send_block(input bit restart, input int style, input int len);
    for (int i = 0; i < len; i++)
      send_word(rand_word(style), rand_word(style), rand_word(style),
                rand_word(style), restart && i == 0);
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the classic "abc" padded block on lane 0, fixed patterns on the others, then four all-ones words.
    calm = 1'b1;
    for (int i = 0; i < 16; i++)
      send_word(i == 0 ? 32'h61626380 : (i == 15 ? 32'h18 : 32'h0),
                32'h0, 32'hffffffff, i == 0 ? 32'h80000000 : 32'h0, i == 0);
    send_block(1'b0, 1, 4);
    // Start flag mid-block: drop the four gathered words and begin afresh.
    send_block(1'b1, 1, 16);
    calm = 1'b0;

    // Hold off until every digest word has drained; drop valid meanwhile.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);

    // Random: mostly chained blocks, now and then a restart, a short abandoned run.
    while (words_sent < 210) begin
      if ($urandom_range(9) == 0) send_block(1'b1, 2, $urandom_range(1, 15));
      else send_block($urandom_range(3) == 0, 2, 16);
      calm = (words_sent > 100 && words_sent < 150);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    waited = 0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    while (waited < 400) begin
      @(posedge clk);
      waited++;
    end
    if (fail_count == 0) $display("sm3_compress_four_lane_test OK");
    else $display("sm3_compress_four_lane_test NOT OK");
    $finish;
  end
endmodule
